// ===== rtl/tcsp_pkg.sv =====
// Shared types and constants for the Telnet command stream parser.
// Used by every module of the block and by the port checker; depends on nothing.
`timescale 1ns / 1ps

package tcsp_pkg;

  // Default size of the command store in bytes.
  localparam int unsigned DEF_BUFFER_BYTES = 32;

  // Protocol bytes.
  localparam logic [7:0] BYTE_IAC  = 8'd255;
  localparam logic [7:0] VERB_WILL = 8'd251;
  localparam logic [7:0] VERB_DONT = 8'd254;

  // Supported options.
  localparam logic [7:0] OPT_BINARY   = 8'd0;
  localparam logic [7:0] OPT_ECHO     = 8'd1;
  localparam logic [7:0] OPT_SGA      = 8'd3;
  localparam logic [7:0] OPT_STATUS   = 8'd5;
  localparam logic [7:0] OPT_TIMING   = 8'd6;

  // Input item kinds.
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_TEXT       = 4'd0,
    ST_HELD       = 4'd1,
    ST_DONE       = 4'd2,
    ST_BAD_VERB   = 4'd3,
    ST_BAD_OPTION = 4'd4,
    ST_FULL       = 4'd5,
    ST_DROPPED    = 4'd6,
    ST_FLUSHED    = 4'd7,
    ST_READ       = 4'd8
  } status_t;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_WAIT_IAC    = 3'b001,
    PH_WAIT_VERB   = 3'b010,
    PH_WAIT_OPTION = 3'b100
  } phase_t;

  // Result of one item as it leaves the parser, before the store read data joins it.
  typedef struct packed {
    status_t    status;
    logic [7:0] text_byte;
    logic [7:0] verb;
    logic [7:0] option;
    logic [3:0] commands_held;
    logic [5:0] bytes_held;
    logic       from_store;
    logic       in_range;
  } result_t;

  // True for WILL, WONT, DO and DONT.
  function automatic logic verb_ok(input logic [7:0] b);
    verb_ok = (b >= VERB_WILL) && (b <= VERB_DONT);
  endfunction

  // True for the options this parser accepts.
  function automatic logic option_ok(input logic [7:0] b);
    option_ok = (b == OPT_BINARY) || (b == OPT_ECHO) || (b == OPT_SGA) ||
                (b == OPT_STATUS) || (b == OPT_TIMING);
  endfunction

endpackage

// ===== rtl/tcsp_store.sv =====
// Command store: one write port and one registered read port.
// Depends on tcsp_pkg for the buffer size default.
`timescale 1ns / 1ps

module tcsp_store
  import tcsp_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES,
  localparam int unsigned AW = $clog2(BUFFER_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read so a stalled result keeps it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/tcsp_ctrl.sv =====
// Parser control: phase, fill and command counters, and store access requests.
// Depends on tcsp_pkg for codes, protocol bytes and the result structure.
`timescale 1ns / 1ps

module tcsp_ctrl
  import tcsp_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES,
  localparam int unsigned AW = $clog2(BUFFER_BYTES),
  localparam int unsigned FW = $clog2(BUFFER_BYTES + 1),
  localparam int unsigned CW = $clog2(BUFFER_BYTES / 3 + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [1:0]    kind,
  input  logic [7:0]    data_byte,
  input  logic [4:0]    read_index,
  output result_t       res,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr
);

  phase_t        phase_r, phase_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] last_end_r, last_end_nxt;
  logic [CW-1:0] done_cnt_r, done_cnt_nxt;
  logic          aborted_r, aborted_nxt;
  logic [7:0]    verb_r, verb_nxt;

  logic          full;
  logic          push;
  logic [FW+4:0] idx_ext;
  logic [CW+3:0] done_ext;
  logic [FW+5:0] fill_ext;

  assign full    = (fill_r == FW'(BUFFER_BYTES));
  assign idx_ext = {{FW{1'b0}}, read_index};

  // Store access: pushes go to the fill position, reads to the requested index.
  assign wr_en   = take && push;
  assign wr_addr = fill_r[AW-1:0];
  assign wr_data = data_byte;
  assign rd_en   = take && (kind_t'(kind) == KIND_READ);
  assign rd_addr = idx_ext[AW-1:0];

  // Decision for one item.
  always_comb begin
    phase_nxt    = phase_r;
    fill_nxt     = fill_r;
    last_end_nxt = last_end_r;
    done_cnt_nxt = done_cnt_r;
    aborted_nxt  = aborted_r;
    verb_nxt     = verb_r;
    push         = 1'b0;
    res          = '0;
    res.status   = ST_DROPPED;

    case (kind_t'(kind))
      KIND_BYTE: begin
        if (aborted_r) begin
          res.status = ST_DROPPED;
        end else begin
          unique case (phase_r)
            PH_WAIT_VERB: begin
              if (data_byte == BYTE_IAC) begin
                // Escaped IAC: drop the IAC held for the command and pass 255 on.
                if (fill_r != '0) begin
                  fill_nxt = fill_r - FW'(1);
                end
                phase_nxt     = PH_WAIT_IAC;
                res.text_byte = BYTE_IAC;
                res.status    = ST_TEXT;
              end else if (!verb_ok(data_byte)) begin
                aborted_nxt = 1'b1;
                res.status  = ST_BAD_VERB;
              end else if (full) begin
                aborted_nxt = 1'b1;
                res.status  = ST_FULL;
              end else begin
                push       = 1'b1;
                fill_nxt   = fill_r + FW'(1);
                verb_nxt   = data_byte;
                phase_nxt  = PH_WAIT_OPTION;
                res.status = ST_HELD;
              end
            end
            PH_WAIT_OPTION: begin
              if (!option_ok(data_byte)) begin
                aborted_nxt = 1'b1;
                res.status  = ST_BAD_OPTION;
              end else if (full) begin
                aborted_nxt = 1'b1;
                res.status  = ST_FULL;
              end else begin
                push         = 1'b1;
                fill_nxt     = fill_r + FW'(1);
                last_end_nxt = fill_r + FW'(1);
                done_cnt_nxt = done_cnt_r + CW'(1);
                phase_nxt    = PH_WAIT_IAC;
                res.verb     = verb_r;
                res.option   = data_byte;
                res.status   = ST_DONE;
              end
            end
            PH_WAIT_IAC: begin
              if (data_byte != BYTE_IAC) begin
                res.text_byte = data_byte;
                res.status    = ST_TEXT;
              end else if (full) begin
                aborted_nxt = 1'b1;
                res.status  = ST_FULL;
              end else begin
                push       = 1'b1;
                fill_nxt   = fill_r + FW'(1);
                phase_nxt  = PH_WAIT_VERB;
                res.status = ST_HELD;
              end
            end
            default: begin
              res.status = ST_DROPPED;
            end
          endcase
        end
      end
      KIND_FLUSH: begin
        // Empty the store only when it holds whole commands and nothing partial.
        aborted_nxt = 1'b0;
        if ((done_cnt_r != '0) && (last_end_r == fill_r)) begin
          fill_nxt     = '0;
          last_end_nxt = '0;
          done_cnt_nxt = '0;
        end
        res.status = ST_FLUSHED;
      end
      KIND_READ: begin
        res.from_store = 1'b1;
        res.in_range   = (idx_ext < (FW+5)'(BUFFER_BYTES));
        res.status     = ST_READ;
      end
      default: begin
        res.status = ST_DROPPED;
      end
    endcase

    // Occupancy as seen after this item, masked to the port widths.
    done_ext          = {4'b0, done_cnt_nxt};
    fill_ext          = {6'b0, fill_nxt};
    res.commands_held = done_ext[3:0];
    res.bytes_held    = (done_cnt_nxt != '0) ? fill_ext[5:0] : 6'd0;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT_IAC;
      fill_r     <= '0;
      last_end_r <= '0;
      done_cnt_r <= '0;
      aborted_r  <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      fill_r     <= fill_nxt;
      last_end_r <= last_end_nxt;
      done_cnt_r <= done_cnt_nxt;
      aborted_r  <= aborted_nxt;
    end
  end

  // Verb of the command being collected.
  always_ff @(posedge clk) begin
    if (take) begin
      verb_r <= verb_nxt;
    end
  end

endmodule

// ===== rtl/tcsp_out.sv =====
// Output register stage: holds one result item and merges in the store read data.
// Depends on tcsp_pkg for the result structure.
`timescale 1ns / 1ps

module tcsp_out
  import tcsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  result_t    res,
  input  logic [7:0] rd_data,
  input  logic       out_stall,
  output logic       out_valid,
  output logic       busy,
  output logic [3:0] out_status,
  output logic [7:0] out_out_byte,
  output logic [7:0] out_verb,
  output logic [7:0] out_option,
  output logic [3:0] out_commands_held,
  output logic [5:0] out_bytes_held
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // The stage is busy while it holds an item that the receiver stalls.
  assign busy = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  // Read items take their byte from the store, zero beyond its end.
  always_comb begin
    if (res_r.from_store) begin
      out_out_byte = res_r.in_range ? rd_data : 8'd0;
    end else begin
      out_out_byte = res_r.text_byte;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = res_r.status;
  assign out_verb          = res_r.verb;
  assign out_option        = res_r.option;
  assign out_commands_held = res_r.commands_held;
  assign out_bytes_held    = res_r.bytes_held;

endmodule

// ===== rtl/telnet_command_stream_parser.sv =====
// Channel  | Ports                                              | Direction
// input    | in_valid, in_stall, in_kind, in_data_byte,         | item in
//          | in_read_index                                      |
// result   | out_valid, out_stall, out_status, out_out_byte,    | item out
//          | out_verb, out_option, out_commands_held,           |
//          | out_bytes_held                                     |
//
// One item is taken per cycle unless stalled; its result is output in the next cycle.
// The store read of a read item and the parser update both happen at the accepting edge.
// Synchronous active-low reset clears the parser state and the output valid; the store
// content is not cleared; read only written entries, which the block does not enforce.
// A stalled result holds the output register and stalls the input only while it waits.
// Top level of the Telnet command stream parser; depends on tcsp_pkg, tcsp_ctrl,
// tcsp_store and tcsp_out.
`timescale 1ns / 1ps

module telnet_command_stream_parser
  import tcsp_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_status,
  output logic [7:0] out_out_byte,
  output logic [7:0] out_verb,
  output logic [7:0] out_option,
  output logic [3:0] out_commands_held,
  output logic [5:0] out_bytes_held
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  logic          take;
  logic          busy;
  result_t       res;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // An item enters whenever the output register is free or being emptied.
  assign in_stall = busy;
  assign take     = in_valid && !busy;

  tcsp_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .kind      (in_kind),
    .data_byte (in_data_byte),
    .read_index(in_read_index),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  tcsp_store #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  tcsp_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .res              (res),
    .rd_data          (rd_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .busy             (busy),
    .out_status       (out_status),
    .out_out_byte     (out_out_byte),
    .out_verb         (out_verb),
    .out_option       (out_option),
    .out_commands_held(out_commands_held),
    .out_bytes_held   (out_bytes_held)
  );

endmodule

// ===== rtl/tcsp_checker.sv =====
// Port-level checks for the Telnet command stream parser, bound to the top level.
// Depends on tcsp_pkg for the status codes.
`timescale 1ns / 1ps

module tcsp_port_checks
  import tcsp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_status,
  input logic [7:0] out_out_byte,
  input logic [7:0] out_verb,
  input logic [7:0] out_option,
  input logic [3:0] out_commands_held,
  input logic [5:0] out_bytes_held
);

  // A stalled result item keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_out_byte))
    else $error("stalled result item changed");

  // Every accepted item produces a result in the next cycle.
  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  // Bytes are only reported while whole commands are held.
  a_bytes_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_commands_held == 4'd0) |-> out_bytes_held == 6'd0)
    else $error("bytes reported with no command held");

  // Only text and read items carry a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_TEXT) && (out_status != ST_READ) |-> out_out_byte == 8'd0)
    else $error("byte set on a non-text, non-read item");

  // Verb and option appear only on a completed command.
  a_cmd_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |-> (out_verb == 8'd0) && (out_option == 8'd0))
    else $error("verb or option set outside a completed command");

endmodule

bind telnet_command_stream_parser tcsp_port_checks u_tcsp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_out_byte     (out_out_byte),
  .out_verb         (out_verb),
  .out_option       (out_option),
  .out_commands_held(out_commands_held),
  .out_bytes_held   (out_bytes_held)
);

// ===== tb/tcsp_checker.sv =====
// Result checker for the Telnet command stream parser: watches both item channels,
// predicts each result from its own copy of the parser state and compares.
// Depends on tcsp_pkg for the status codes, item kinds, parser phases and protocol bytes.
`timescale 1ns / 1ps

module tcsp_checker
  import tcsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_read_index,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] out_status,
  input  logic [7:0] out_out_byte,
  input  logic [7:0] out_verb,
  input  logic [7:0] out_option,
  input  logic [3:0] out_commands_held,
  input  logic [5:0] out_bytes_held,
  output int         fail_count,
  output int         pending_items,
  output int         commands_checked,
  output int         store_written,
  output int         pred_fill,
  output int         pred_done,
  output int         pred_last_end,
  output phase_t     pred_phase
);

  localparam int STORE_BYTES = DEF_BUFFER_BYTES;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    status_t    status;
    logic [7:0] out_byte;
    logic [7:0] verb;
    logic [7:0] option;
    logic [3:0] commands;
    logic [5:0] bytes;
  } parse_result_t;

  // Shadow of the parser state.
  phase_t     phase = PH_WAIT_IAC;
  logic [7:0] store [STORE_BYTES];
  int         fill = 0;
  int         done_cnt = 0;
  int         last_end = 0;
  int         written = 0;
  bit         aborted = 1'b0;

  parse_result_t expected_q[$];
  int failures = 0;
  int commands_ok = 0;

  // Appends one command byte; returns 0 when the store is already full.
  function automatic bit hold_command_byte(input logic [7:0] b);
    if (fill >= STORE_BYTES) return 1'b0;
    store[fill] = b;
    fill++;
    if (fill > written) written = fill;
    return 1'b1;
  endfunction

  // Advances the shadow state by one accepted item and returns the result it causes.
  function automatic parse_result_t predict_result(input logic [1:0] kind,
                                                   input logic [7:0] b,
                                                   input logic [4:0] idx);
    parse_result_t r;
    r.status   = ST_DROPPED;
    r.out_byte = '0;
    r.verb     = '0;
    r.option   = '0;
    case (kind)
      KIND_BYTE: begin
        if (aborted) begin
          r.status = ST_DROPPED;
        end else if (phase == PH_WAIT_VERB) begin
          // A second IAC escapes a literal 255 and releases the held IAC.
          if (b == BYTE_IAC) begin
            if (fill > 0) fill--;
            phase      = PH_WAIT_IAC;
            r.status   = ST_TEXT;
            r.out_byte = BYTE_IAC;
          end else if (!(b inside {[VERB_WILL:VERB_DONT]})) begin
            aborted  = 1'b1;
            r.status = ST_BAD_VERB;
          end else if (!hold_command_byte(b)) begin
            aborted  = 1'b1;
            r.status = ST_FULL;
          end else begin
            phase    = PH_WAIT_OPTION;
            r.status = ST_HELD;
          end
        end else if (phase == PH_WAIT_OPTION) begin
          if (!(b inside {OPT_BINARY, OPT_ECHO, OPT_SGA, OPT_STATUS, OPT_TIMING})) begin
            aborted  = 1'b1;
            r.status = ST_BAD_OPTION;
          end else if (!hold_command_byte(b)) begin
            aborted  = 1'b1;
            r.status = ST_FULL;
          end else begin
            done_cnt++;
            last_end = fill;
            phase    = PH_WAIT_IAC;
            r.status = ST_DONE;
            r.verb   = (fill >= 2) ? store[fill-2] : 8'd0;
            r.option = b;
          end
        end else if (b != BYTE_IAC) begin
          r.status   = ST_TEXT;
          r.out_byte = b;
        end else if (!hold_command_byte(b)) begin
          aborted  = 1'b1;
          r.status = ST_FULL;
        end else begin
          phase    = PH_WAIT_VERB;
          r.status = ST_HELD;
        end
      end
      KIND_FLUSH: begin
        // The store is emptied only when it holds whole commands and nothing partial.
        aborted = 1'b0;
        if (done_cnt > 0 && last_end == fill) begin
          fill     = 0;
          last_end = 0;
          done_cnt = 0;
        end
        r.status = ST_FLUSHED;
      end
      KIND_READ: begin
        r.out_byte = (idx < STORE_BYTES) ? store[idx] : 8'd0;
        r.status   = ST_READ;
      end
      default: begin
        // The unused kind is ignored.
        r.status = ST_DROPPED;
      end
    endcase
    r.commands = done_cnt[3:0];
    r.bytes    = (done_cnt > 0) ? fill[5:0] : 6'd0;
    return r;
  endfunction

  // Compare each accepted result with the oldest expectation, then take in the new item.
  always @(posedge clk) begin : watch_channels
    parse_result_t want;
    if (!rst_n) begin
      phase    = PH_WAIT_IAC;
      fill     = 0;
      done_cnt = 0;
      last_end = 0;
      aborted  = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("%0t: result with status %0d arrived with no item outstanding",
                     $time, out_status);
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status || out_out_byte !== want.out_byte ||
              out_verb !== want.verb || out_option !== want.option ||
              out_commands_held !== want.commands || out_bytes_held !== want.bytes) begin
            failures++;
            if (failures <= REPORT_LIMIT)
              $display({"%0t: result mismatch, expected status %0d byte %0d verb %0d ",
                        "option %0d commands %0d bytes %0d, got %0d %0d %0d %0d %0d %0d"},
                       $time, want.status, want.out_byte, want.verb, want.option,
                       want.commands, want.bytes, out_status, out_out_byte, out_verb,
                       out_option, out_commands_held, out_bytes_held);
          end else if (want.status == ST_DONE) begin
            commands_ok++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_result(in_kind, in_data_byte, in_read_index));
    end
    fail_count       <= failures;
    pending_items    <= expected_q.size();
    commands_checked <= commands_ok;
    store_written    <= written;
    pred_fill        <= fill;
    pred_done        <= done_cnt;
    pred_last_end    <= last_end;
    pred_phase       <= phase;
  end

endmodule

// ===== tb/tb_telnet_command_stream_parser.sv =====
// Testbench top for the Telnet command stream parser: clock, reset, item stimulus and verdict.
// Depends on tcsp_pkg, the parser RTL and tcsp_checker, which predicts and compares results.
`timescale 1ns / 1ps

module tb_telnet_command_stream_parser;
  import tcsp_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_PCT      = 30;
  localparam int RANDOM_ITEMS  = 900;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int CMD_FILL_MAX  = 26;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_kind = KIND_BYTE;
  logic [7:0] in_data_byte = '0;
  logic [4:0] in_read_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_status;
  logic [7:0] out_out_byte;
  logic [7:0] out_verb;
  logic [7:0] out_option;
  logic [3:0] out_commands_held;
  logic [5:0] out_bytes_held;

  int     fail_count;
  int     pending_items;
  int     commands_checked;
  int     store_written;
  int     pred_fill;
  int     pred_done;
  int     pred_last_end;
  phase_t pred_phase;

  int cycles = 0;
  int items_sent = 0;
  int reads_sent = 0;
  int chunks_sent = 0;
  int idle_pct = IDLE_PCT;
  bit stall_free = 1'b0;

  telnet_command_stream_parser dut (.*);

  tcsp_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // The result side stalls at random, except during the stall-free stretch.
  always @(posedge clk) begin
    out_stall <= !stall_free && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Presents one item after a random gap and holds it until it is accepted.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                           input logic [4:0] idx);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_data_byte  <= data;
    in_read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind != KIND_UNUSED) items_sent++;
    if (kind == KIND_READ) reads_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(KIND_BYTE, b, 5'($urandom_range(0, 31)));
  endtask

  task automatic send_flush();
    send_item(KIND_FLUSH, 8'($urandom), 5'($urandom));
  endtask

  task automatic send_command(input logic [7:0] verb, input logic [7:0] option);
    send_byte(BYTE_IAC);
    send_byte(verb);
    send_byte(option);
  endtask

  // Reads only store entries that some earlier item has written.
  task automatic send_read_any();
    if (store_written > 0)
      send_item(KIND_READ, 8'($urandom), 5'($urandom_range(0, store_written - 1)));
  endtask

  function automatic logic [7:0] pick_verb();
    return VERB_WILL + 8'($urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 4))
      0: return OPT_BINARY;
      1: return OPT_ECHO;
      2: return OPT_SGA;
      3: return OPT_STATUS;
      default: return OPT_TIMING;
    endcase
  endfunction

  function automatic logic [7:0] pick_bad_option();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 250));
    while (b inside {OPT_BINARY, OPT_ECHO, OPT_SGA, OPT_STATUS, OPT_TIMING});
    return b;
  endfunction

  // Starts a chunk with a flush item. The predicted state seen at its acceptance is the
  // state before the flush; any partial command is then completed or released so that
  // the store level stays known. Loose chunks sometimes leave the partial as it is.
  task automatic start_chunk(input bit loose, output int fill_est);
    send_flush();
    chunks_sent++;
    fill_est = (pred_done > 0 && pred_last_end == pred_fill) ? 0 : pred_fill;
    if (loose && fill_est < 20 && $urandom_range(0, 3) == 0) begin
      fill_est += 2;
    end else if (pred_phase == PH_WAIT_VERB) begin
      send_byte(BYTE_IAC);
      fill_est--;
    end else if (pred_phase == PH_WAIT_OPTION) begin
      send_byte(pick_option());
      fill_est++;
    end
  endtask

  initial begin
    int  fill_est;
    int  segs;
    int  pick;
    int  base;
    bit  broken;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: text extremes, the unused kind, the escaped IAC, commands, a read, aborts and flushes.
    send_byte(8'h00);
    send_byte(8'hFE);
    send_item(KIND_UNUSED, 8'hFF, 5'h1F);
    send_byte(BYTE_IAC);
    send_byte(BYTE_IAC);
    send_command(VERB_WILL, OPT_BINARY);
    send_command(VERB_DONT, OPT_TIMING);
    send_item(KIND_READ, 8'h00, 5'd0);
    send_byte(BYTE_IAC);
    send_byte(VERB_WILL + 8'd1);
    send_byte(8'd2);
    send_byte(8'h41);
    // Partial command held: the flush must leave the store alone.
    send_flush();
    send_byte(OPT_ECHO);
    send_flush();
    send_byte(BYTE_IAC);
    send_byte(8'h41);
    send_flush();
    send_byte(BYTE_IAC);
    send_command(VERB_DONT - 8'd1, OPT_SGA);

    // Random part: chunks of well-formed traffic with some noise and broken commands.
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      stall_free <= (items_sent - base) inside {[300:500]};
      idle_pct = ((items_sent - base) inside {[300:500]}) ? 0 : IDLE_PCT;
      start_chunk(1'b1, fill_est);
      if (fill_est == 0 && $urandom_range(0, 19) == 0) begin
        // Fill the store with the most whole commands it can hold.
        repeat (10) send_command(pick_verb(), pick_option());
        continue;
      end
      segs   = $urandom_range(1, 8);
      broken = 1'b0;
      for (int s = 0; s < segs && !broken; s++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40 && fill_est <= CMD_FILL_MAX) begin
          send_command(pick_verb(), pick_option());
          fill_est += 3;
        end else if (pick < 70) begin
          send_byte(8'($urandom_range(0, 254)));
        end else if (pick < 78) begin
          send_byte(BYTE_IAC);
          send_byte(BYTE_IAC);
        end else if (pick < 88) begin
          send_read_any();
        end else if (pick < 91) begin
          send_item(KIND_UNUSED, 8'($urandom), 5'($urandom));
        end else begin
          broken = 1'b1;
          send_byte(BYTE_IAC);
          case ($urandom_range(0, 2))
            0: send_byte(8'($urandom_range(0, 250)));
            1: begin
              send_byte(pick_verb());
              send_byte(pick_bad_option());
            end
            default: send_byte(pick_verb());
          endcase
        end
      end
      // Bytes after a broken command are plain printable ones, which push nothing.
      if (broken) repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(32, 126)));
    end
    stall_free <= 1'b0;
    idle_pct = IDLE_PCT;

    // Closing part: overflow the store. It stays full for the rest of the run.
    start_chunk(1'b0, fill_est);
    send_flush();
    repeat (10) send_command(pick_verb(), pick_option());
    send_command(pick_verb(), pick_option());
    send_byte(8'h41);
    send_flush();
    send_byte(OPT_ECHO);
    send_byte(pick_bad_option());
    send_item(KIND_READ, 8'h00, 5'd31);
    send_item(KIND_READ, 8'hFF, 5'd0);
    repeat (6) send_read_any();
    send_item(KIND_UNUSED, 8'($urandom), 5'($urandom));

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_items != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items in %0d chunks, %0d of them store reads.",
             items_sent, chunks_sent, reads_sent);
    $display("%0d completed commands matched; %0d failures.", commands_checked, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
